// File: hw/rtl/field_comb_block_analyzer_unit_defines.svh
// Assertion macros shared by the comb analyzer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIELD_COMB_BLOCK_ANALYZER_UNIT_DEFINES_SVH
`define FIELD_COMB_BLOCK_ANALYZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/fcba_pkg.sv
// Shared types, constants and pixel arithmetic for the comb analyzer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fcba_pkg;

   localparam int COLUMNS_PER_BLOCK = 8;
   localparam int COUNT_W           = $clog2(COLUMNS_PER_BLOCK);
   localparam logic [COUNT_W-1:0] LAST_COLUMN = COUNT_W'(COLUMNS_PER_BLOCK - 1);

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_SHIFT    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_FIELD_FIRST = 4'd1;

   localparam logic [7:0] LEVEL_MAX = 8'd255;

   typedef logic [7:0][7:0]    pix_col_type;   // row k in bits 8k+7..8k
   typedef logic signed [12:0] metric_type;    // comb metric of one column
   typedef logic [9:0]         motion_type;    // four abs diffs of one column
   typedef logic signed [15:0] sum_type;
   typedef logic [7:0]         level_type;

   typedef struct packed {
      logic [3:0] result_shift;
      logic       top_field_first;
   } cfg_type;

   typedef struct packed {
      metric_type own_comb;
      metric_type mix_comb;
      motion_type even_motion;
      motion_type odd_motion;
   } metrics_type;

   function automatic logic [7:0] absd(input logic [7:0] x, input logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   // T - E - O folds to sum7 + d8 - e4 - o4
   function automatic metric_type comb_metric(input pix_col_type l);
      logic [7:0]  d8;
      logic [10:0] t_sum;
      logic [9:0]  e_sum;
      logic [9:0]  o_sum;
      d8    = absd(l[0], l[7]);
      t_sum = 11'(absd(l[0], l[1])) + 11'(absd(l[1], l[2])) + 11'(absd(l[2], l[3]))
            + 11'(absd(l[3], l[4])) + 11'(absd(l[4], l[5])) + 11'(absd(l[5], l[6]))
            + 11'(absd(l[6], l[7]));
      e_sum = 10'(absd(l[0], l[2])) + 10'(absd(l[2], l[4])) + 10'(absd(l[4], l[6]))
            + 10'(absd(l[6], l[7]));
      o_sum = 10'(absd(l[0], l[1])) + 10'(absd(l[1], l[3])) + 10'(absd(l[3], l[5]))
            + 10'(absd(l[5], l[7]));
      return $signed({2'b00, t_sum}) + $signed({5'b00000, d8})
           - $signed({3'b000, e_sum}) - $signed({3'b000, o_sum});
   endfunction

   // negative clamps to zero, then shift and saturate
   function automatic level_type finish_sum(input sum_type s, input logic [3:0] shift);
      logic [14:0] v;
      v = s[14:0] >> shift;
      if (s[15]) begin
         return '0;
      end
      return (|v[14:8]) ? LEVEL_MAX : v[7:0];
   endfunction

endpackage

// File: hw/rtl/fcba_metrics.sv
// Per-column metrics: own and woven comb metrics, even/odd inter-field motion.
// Pure logic between the input register and the accumulators; uses fcba_pkg.
`timescale 1ns / 1ps

module fcba_metrics (
   input  fcba_pkg::pix_col_type first_col,
   input  fcba_pkg::pix_col_type second_col,
   input  logic                  top_field_first,
   output fcba_pkg::metrics_type metrics
);

   fcba_pkg::pix_col_type mixed_col;

   // weave: even rows from the second field when top field first
   always_comb begin
      mixed_col[0] = top_field_first ? second_col[0] : first_col[0];
      mixed_col[1] = top_field_first ? first_col[1]  : second_col[1];
      mixed_col[2] = top_field_first ? second_col[2] : first_col[2];
      mixed_col[3] = top_field_first ? first_col[3]  : second_col[3];
      mixed_col[4] = top_field_first ? second_col[4] : first_col[4];
      mixed_col[5] = top_field_first ? first_col[5]  : second_col[5];
      mixed_col[6] = top_field_first ? second_col[6] : first_col[6];
      mixed_col[7] = top_field_first ? first_col[7]  : second_col[7];
   end

   always_comb begin
      metrics.own_comb    = fcba_pkg::comb_metric(first_col);
      metrics.mix_comb    = fcba_pkg::comb_metric(mixed_col);
      metrics.even_motion =
         10'(fcba_pkg::absd(first_col[0], second_col[0]))
       + 10'(fcba_pkg::absd(first_col[2], second_col[2]))
       + 10'(fcba_pkg::absd(first_col[4], second_col[4]))
       + 10'(fcba_pkg::absd(first_col[6], second_col[6]));
      metrics.odd_motion =
         10'(fcba_pkg::absd(first_col[1], second_col[1]))
       + 10'(fcba_pkg::absd(first_col[3], second_col[3]))
       + 10'(fcba_pkg::absd(first_col[5], second_col[5]))
       + 10'(fcba_pkg::absd(first_col[7], second_col[7]));
   end

endmodule

// File: hw/rtl/fcba_accum.sv
// Block accumulators, column counter and the result register.
// Uses fcba_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "field_comb_block_analyzer_unit_defines.svh"

module fcba_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  col_valid,
   input  fcba_pkg::metrics_type metrics,
   input  fcba_pkg::cfg_type     cfg,
   output logic                  col_taken,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fcba_pkg::level_type   rsp_top_comb_level,
   output fcba_pkg::level_type   rsp_even_row_motion,
   output fcba_pkg::level_type   rsp_bottom_comb_level,
   output fcba_pkg::level_type   rsp_odd_row_motion
);

   fcba_pkg::sum_type              sum_ff [4];
   fcba_pkg::sum_type              sum_in [4];
   fcba_pkg::sum_type              delta  [4];
   logic [fcba_pkg::COUNT_W-1:0]   count_ff;
   logic [fcba_pkg::COUNT_W-1:0]   count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   fcba_pkg::level_type            level_ff [4];
   fcba_pkg::level_type            level_in [4];
   fcba_pkg::sum_type              sum_next [4];
   logic                           last_col;
   logic                           emit;

   assign last_col  = (count_ff == fcba_pkg::LAST_COLUMN);
   // a non-final column never touches the result register
   assign col_taken = col_valid && (!last_col || !rsp_valid_ff || rsp_ready);
   assign emit      = col_taken && last_col;

   always_comb begin
      delta[0] = cfg.top_field_first ? 16'(metrics.own_comb) : 16'(metrics.mix_comb);
      delta[2] = cfg.top_field_first ? 16'(metrics.mix_comb) : 16'(metrics.own_comb);
      delta[1] = {6'b000000, metrics.even_motion};
      delta[3] = {6'b000000, metrics.odd_motion};
      for (int s = 0; s < 4; s++) begin
         sum_next[s] = sum_ff[s] + delta[s];
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int s = 0; s < 4; s++) begin
         sum_in[s]   = sum_ff[s];
         level_in[s] = level_ff[s];
      end
      if (col_taken) begin
         count_in = count_ff + 1'b1;
         for (int s = 0; s < 4; s++) begin
            sum_in[s] = sum_next[s];
         end
      end
      if (emit) begin
         // close the block: load result, clear sums
         count_in     = '0;
         rsp_valid_in = 1'b1;
         for (int s = 0; s < 4; s++) begin
            level_in[s] = fcba_pkg::finish_sum(sum_next[s], cfg.result_shift);
            sum_in[s]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 4; s++) begin
            sum_ff[s] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < 4; s++) begin
            sum_ff[s] <= sum_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < 4; s++) begin
         level_ff[s] <= level_in[s];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_top_comb_level    = level_ff[0];
   assign rsp_even_row_motion   = level_ff[1];
   assign rsp_bottom_comb_level = level_ff[2];
   assign rsp_odd_row_motion    = level_ff[3];

   `FCBA_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !emit, "pending result overwritten")
   `FCBA_ASSERT_NEXT(a_emit_valid, clock, reset, emit, rsp_valid_ff && (count_ff == '0), "block close did not raise result")
   `FCBA_ASSERT_NEXT(a_emit_clear, clock, reset, emit, (sum_ff[0] == '0) && (sum_ff[1] == '0) && (sum_ff[2] == '0) && (sum_ff[3] == '0), "sums not cleared at block close")
   `FCBA_ASSERT_NEXT(a_count_step, clock, reset, col_taken && !last_col, count_ff == $past(count_ff) + 1'b1, "column count did not advance")

endmodule

// File: hw/rtl/field_comb_block_analyzer_unit.sv
// Top level of the interlace comb analyzer: input register, CSRs, metrics, accumulators.
// Depends on fcba_pkg, fcba_metrics and fcba_accum.
//
//  channel  dir  handshake              word
//  req      in   req_valid/req_ready    one pixel column of each field (2 x 64 bits)
//  rsp      out  rsp_valid/rsp_ready    four 8-bit levels, one per 8 columns
//  csr      in   csr_valid/csr_ready    register index + write data
//
// One column is accepted every cycle while no pending result holds a block's final column;
// the last column of a block passes the input register, then the result register.
// A result appears after every eighth accepted column.
// Synchronous active-high reset clears the sums, column count and valids, and sets the CSRs
// to shift 0, top field first. A result left waiting stalls only the block's final column;
// earlier columns keep flowing. csr_ready is always high; writes to an index outside the map are dropped.
`timescale 1ns / 1ps

module field_comb_block_analyzer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [63:0]                          req_first_field_column,
   input  logic [63:0]                          req_second_field_column,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_top_comb_level,
   output logic [7:0]                           rsp_even_row_motion,
   output logic [7:0]                           rsp_bottom_comb_level,
   output logic [7:0]                           rsp_odd_row_motion,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcba_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fcba_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   fcba_pkg::cfg_type     cfg_ff;
   fcba_pkg::cfg_type     cfg_in;
   logic                  col_valid_ff;
   logic                  col_valid_in;
   fcba_pkg::pix_col_type first_ff;
   fcba_pkg::pix_col_type second_ff;
   fcba_pkg::metrics_type metrics;
   logic                  col_taken;
   logic                  req_fire;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fcba_pkg::CSR_RESULT_SHIFT:    cfg_in.result_shift    = csr_wdata[3:0];
            fcba_pkg::CSR_TOP_FIELD_FIRST: cfg_in.top_field_first = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.result_shift    <= 4'd0;
         cfg_ff.top_field_first <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register: refill when empty or whenever the held word moves on
   assign req_ready    = !col_valid_ff || col_taken;
   assign req_fire     = req_valid && req_ready;
   assign col_valid_in = req_fire || (col_valid_ff && !col_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= 1'b0;
      end else begin
         col_valid_ff <= col_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         first_ff  <= req_first_field_column;
         second_ff <= req_second_field_column;
      end
   end

   fcba_metrics u_metrics (
      .first_col       (first_ff),
      .second_col      (second_ff),
      .top_field_first (cfg_ff.top_field_first),
      .metrics         (metrics)
   );

   fcba_accum u_accum (
      .clock                 (clock),
      .reset                 (reset),
      .col_valid             (col_valid_ff),
      .metrics               (metrics),
      .cfg                   (cfg_ff),
      .col_taken             (col_taken),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_top_comb_level    (rsp_top_comb_level),
      .rsp_even_row_motion   (rsp_even_row_motion),
      .rsp_bottom_comb_level (rsp_bottom_comb_level),
      .rsp_odd_row_motion    (rsp_odd_row_motion)
   );

endmodule
